// ===== hw/rtl/omrb_pkg.sv =====
// shared types and constants of the overwriting message ring buffer
`timescale 1ns / 1ps

package omrb_pkg;

  // built size of the ring and width of a stored word
  localparam int MAX_DEPTH    = 16;
  localparam int PAYLOAD_BITS = 64;
  localparam int ID_W         = 32;
  localparam int PAYLOAD_W    = 64;
  localparam int DEPTH_W      = 5;
  localparam int PTR_W        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W        = $clog2(MAX_DEPTH + 1);

  // depth register after reset
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(16);

  // operation codes
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // one stored message
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic [PAYLOAD_BITS-1:0] payload;
  } slot_t;

  // access request toward the message memory
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    slot_t            wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/overwriting_message_ring_buffer.sv =====
// top level of the overwriting message ring buffer
`timescale 1ns / 1ps

// Ring FIFO of messages (32-bit id plus payload) that drops the oldest word
// when a push finds it full.
// Command channel: op, in_msg_id and in_payload are taken at a rising edge
// with start high and busy low. busy stays low, so a command can be given in
// every cycle: one command per cycle sustained.
// Result channel: done is high for exactly one cycle, the cycle after the
// command was taken. During that cycle out_msg_id / out_payload
// carry the popped word (zero for anything but a successful pop) and
// data_lost, empty_pop, fill_count, is_full, is_empty give status after it.
// The delay of the result is set by the registered read port of the memory.
// The receiver cannot stall; every result is taken in its done cycle.
// Configuration: depth_we writes depth_in_use (slots in use; zero acts as
// one, above the built depth acts as the built depth) and empties the ring;
// flags are kept. Write it only while no result is pending.
// Reset (rst, synchronous): ring empty, flags clear, depth at its maximum.
// Memory contents are not cleared; only written entries are ever read.
module overwriting_message_ring_buffer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          op,
  input  logic [omrb_pkg::ID_W-1:0]           in_msg_id,
  input  logic [omrb_pkg::PAYLOAD_W-1:0]      in_payload,
  input  logic                                depth_we,
  input  logic [omrb_pkg::DEPTH_W-1:0]        depth_in_use,
  output logic                                done,
  output logic [omrb_pkg::ID_W-1:0]           out_msg_id,
  output logic [omrb_pkg::PAYLOAD_W-1:0]      out_payload,
  output logic                                data_lost,
  output logic                                empty_pop,
  output logic [omrb_pkg::DEPTH_W-1:0]        fill_count,
  output logic                                is_full,
  output logic                                is_empty
);

  logic [omrb_pkg::DEPTH_W-1:0] depth_reg;
  logic [omrb_pkg::PTR_W-1:0]   wr_ptr;
  logic [omrb_pkg::PTR_W-1:0]   wr_ptr_next;
  logic [omrb_pkg::PTR_W-1:0]   rd_ptr;
  logic [omrb_pkg::PTR_W-1:0]   rd_ptr_next;
  logic [omrb_pkg::CNT_W-1:0]   held;
  logic [omrb_pkg::CNT_W-1:0]   held_next;
  logic                         lost_flag;
  logic                         lost_flag_next;
  logic                         under_flag;
  logic                         under_flag_next;
  logic                         pop_hit;
  logic                         pop_hit_next;

  logic [omrb_pkg::CNT_W-1:0]   eff_depth;
  logic [omrb_pkg::CNT_W-1:0]   wr_inc;
  logic [omrb_pkg::CNT_W-1:0]   rd_inc;
  logic [omrb_pkg::PTR_W-1:0]   wr_adv;
  logic [omrb_pkg::PTR_W-1:0]   rd_adv;
  logic                         accept;
  logic                         ring_full;
  omrb_pkg::op_t                op_code;
  omrb_pkg::ram_req_t           ram_req;
  omrb_pkg::slot_t              ram_rd;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign op_code = omrb_pkg::op_t'(op);

  // effective depth, clamped to one..built depth
  always_comb begin
    if (depth_reg == '0) begin
      eff_depth = omrb_pkg::CNT_W'(1);
    end else if (omrb_pkg::CNT_W'(depth_reg) > omrb_pkg::CNT_W'(omrb_pkg::MAX_DEPTH)
                 || (omrb_pkg::DEPTH_W > omrb_pkg::CNT_W
                     && (depth_reg >> omrb_pkg::CNT_W) != '0)) begin
      eff_depth = omrb_pkg::CNT_W'(omrb_pkg::MAX_DEPTH);
    end else begin
      eff_depth = omrb_pkg::CNT_W'(depth_reg);
    end
  end

  // pointer advance with wrap at the effective depth
  assign wr_inc    = omrb_pkg::CNT_W'(wr_ptr) + omrb_pkg::CNT_W'(1);
  assign rd_inc    = omrb_pkg::CNT_W'(rd_ptr) + omrb_pkg::CNT_W'(1);
  assign wr_adv    = (wr_inc >= eff_depth) ? '0 : wr_inc[omrb_pkg::PTR_W-1:0];
  assign rd_adv    = (rd_inc >= eff_depth) ? '0 : rd_inc[omrb_pkg::PTR_W-1:0];
  assign ring_full = (held >= eff_depth);

  // command decode and state update
  always_comb begin
    wr_ptr_next     = wr_ptr;
    rd_ptr_next     = rd_ptr;
    held_next       = held;
    lost_flag_next  = lost_flag;
    under_flag_next = under_flag;
    pop_hit_next    = 1'b0;
    ram_req.we      = 1'b0;
    ram_req.waddr   = wr_ptr;
    ram_req.wdata.id      = in_msg_id;
    ram_req.wdata.payload = in_payload[omrb_pkg::PAYLOAD_BITS-1:0];
    ram_req.re      = 1'b0;
    ram_req.raddr   = rd_ptr;
    if (accept) begin
      case (op_code)
        omrb_pkg::OP_PUSH: begin
          ram_req.we      = 1'b1;
          wr_ptr_next     = wr_adv;
          under_flag_next = 1'b0;
          if (ring_full) begin
            rd_ptr_next    = rd_adv;
            lost_flag_next = 1'b1;
          end else begin
            held_next = held + omrb_pkg::CNT_W'(1);
          end
        end
        omrb_pkg::OP_POP: begin
          if (held == '0) begin
            under_flag_next = 1'b1;
          end else begin
            ram_req.re     = 1'b1;
            pop_hit_next   = 1'b1;
            rd_ptr_next    = rd_adv;
            held_next      = held - omrb_pkg::CNT_W'(1);
            lost_flag_next = 1'b0;
          end
        end
        omrb_pkg::OP_CLEAR: begin
          lost_flag_next  = 1'b0;
          under_flag_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
    // depth write empties the ring
    if (depth_we) begin
      wr_ptr_next = '0;
      rd_ptr_next = '0;
      held_next   = '0;
    end
  end

  // control and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_reg  <= omrb_pkg::DEPTH_RESET;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      held       <= '0;
      lost_flag  <= 1'b0;
      under_flag <= 1'b0;
      pop_hit    <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (depth_we) begin
        depth_reg <= depth_in_use;
      end
      wr_ptr     <= wr_ptr_next;
      rd_ptr     <= rd_ptr_next;
      held       <= held_next;
      lost_flag  <= lost_flag_next;
      under_flag <= under_flag_next;
      pop_hit    <= pop_hit_next;
      done       <= accept;
    end
  end

  omrb_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  // result word: memory data only for a successful pop
  assign out_msg_id  = pop_hit ? ram_rd.id : '0;
  assign out_payload = pop_hit ? omrb_pkg::PAYLOAD_W'(ram_rd.payload) : '0;
  assign data_lost   = lost_flag;
  assign empty_pop   = under_flag;
  assign fill_count  = omrb_pkg::DEPTH_W'(held);
  assign is_full     = ring_full;
  assign is_empty    = (held == '0);

  // every taken command gives a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("command without result");

  // a push never leaves the ring empty and clears the empty-pop flag
  assert property (@(posedge clk) disable iff (rst)
    (accept && op == omrb_pkg::OP_PUSH && !depth_we) |=> (!is_empty && !empty_pop))
    else $error("push left ring empty or flag set");

  // a pop of an empty ring flags it and returns a zero word
  assert property (@(posedge clk) disable iff (rst)
    (accept && op == omrb_pkg::OP_POP && is_empty)
      |=> (empty_pop && out_msg_id == '0 && out_payload == '0))
    else $error("empty pop misreported");

  // a successful pop clears the lost flag and frees a slot
  assert property (@(posedge clk) disable iff (rst)
    (accept && op == omrb_pkg::OP_POP && !is_empty && !depth_we)
      |=> (!data_lost && !is_full))
    else $error("pop left ring full or lost flag set");

  // fill count never exceeds the depth in use
  assert property (@(posedge clk) disable iff (rst)
    held <= eff_depth)
    else $error("fill count above depth");

endmodule

// ===== hw/rtl/omrb_ram.sv =====
// message memory: one write and one registered read per cycle
`timescale 1ns / 1ps

module omrb_ram (
  input  logic              clk,
  input  omrb_pkg::ram_req_t req,
  output omrb_pkg::slot_t   rd_data
);

  omrb_pkg::slot_t mem [omrb_pkg::MAX_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule
